@@ rtl/aes_pkg.sv @@
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } aes_out_t;

    typedef logic [127:0] aes_state_t;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [16] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,
        8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a,8'h2f
    };

    // byte i sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(aes_state_t s, int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic aes_state_t next_key(aes_state_t k, logic [3:0] rnd);
        logic [7:0] kb [16];
        logic [7:0] t [4];
        aes_state_t res;
        for (int i = 0; i < 16; i++)
        begin
            kb[i] = get_byte(k, i);
        end
        t[0] = SBOX[kb[13]] ^ RCON[rnd];
        t[1] = SBOX[kb[14]];
        t[2] = SBOX[kb[15]];
        t[3] = SBOX[kb[12]];
        for (int i = 0; i < 4; i++)
        begin
            kb[i] = kb[i] ^ t[i];
        end
        for (int i = 4; i < 16; i++)
        begin
            kb[i] = kb[i] ^ kb[i - 4];
        end
        for (int i = 0; i < 16; i++)
        begin
            res[127 - 8 * i -: 8] = kb[i];
        end
        return res;
    endfunction

    function automatic aes_state_t sub_shift(aes_state_t s);
        aes_state_t res;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                res[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
            end
        end
        return res;
    endfunction

    function automatic aes_state_t mix_columns(aes_state_t s);
        aes_state_t res;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            res[127 - 32 * c -: 8]  = a0 ^ all ^ xtime(a0 ^ a1);
            res[119 - 32 * c -: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            res[111 - 32 * c -: 8]  = a2 ^ all ^ xtime(a2 ^ a3);
            res[103 - 32 * c -: 8]  = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return res;
    endfunction

endpackage

@@ rtl/aes_round_cell.sv @@
module aes_round_cell
    import aes_pkg::*;
#(
    parameter logic [3:0] RND = 4'd0,
    parameter bit LAST = 1'b0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       valid_in,
    input  aes_state_t state_in,
    input  aes_state_t key_in,
    output logic       valid_out,
    output aes_state_t state_out,
    output aes_state_t key_out
);

    logic       valid_reg;
    aes_state_t state_reg;
    aes_state_t key_reg;
    aes_state_t key_next;
    aes_state_t state_next;
    aes_state_t ss;

    always_comb
    begin
        key_next = next_key(key_in, RND);
        ss = sub_shift(state_in);
        state_next = (LAST ? ss : mix_columns(ss)) ^ key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg <= key_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out = key_reg;

endmodule

@@ rtl/aes128_block_encrypt_unit.sv @@
// an input register, then one registered pipeline cell per round, from accepted input item to output item
// throughput: one item per cycle while the output is not stalled, one pipeline cell per round
// the whole chain stalls together when the output item is not taken
// reset clears all valid bits and both key registers to zero
module aes128_block_encrypt_unit
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  aes_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output aes_out_t    out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        v0_reg;
    aes_state_t  s0_reg;
    aes_state_t  k0_reg;
    logic        advance;

    logic       vc [ROUND_COUNT + 1];
    aes_state_t sc [ROUND_COUNT + 1];
    aes_state_t kc [ROUND_COUNT + 1];

    assign advance = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            v0_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LOW:  key_low_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (advance)
            begin
                v0_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= {in_data.block_high, in_data.block_low} ^ {key_high_reg, key_low_reg};
            k0_reg <= {key_high_reg, key_low_reg};
        end
    end

    assign vc[0] = v0_reg;
    assign sc[0] = s0_reg;
    assign kc[0] = k0_reg;

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        aes_round_cell #(
            .RND  (4'(r)),
            .LAST (r == ROUND_COUNT - 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (vc[r]),
            .state_in  (sc[r]),
            .key_in    (kc[r]),
            .valid_out (vc[r + 1]),
            .state_out (sc[r + 1]),
            .key_out   (kc[r + 1])
        );
    end

    assign out_valid = vc[ROUND_COUNT];
    assign out_data.cipher_high = sc[ROUND_COUNT][127:64];
    assign out_data.cipher_low = sc[ROUND_COUNT][63:0];

endmodule

@@ rtl/aes_checker.sv @@
module aes_checker
    import aes_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input aes_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item dropped or changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import aes_pkg::*;

    localparam int ROUNDS = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic [127:0] key;
        logic [127:0] plain;
        logic [127:0] cipher;
        bit           typed;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    aes_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    aes_out_t    out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    logic [7:0]   sub_lut [256];
    logic [127:0] cur_key;
    aes_out_t     cipher_q [$];
    int           send_idle;
    int           recv_idle;
    int           errors;
    int           cycles;

    aes128_block_encrypt_unit #(.ROUND_COUNT(ROUNDS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] gf_double(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p = p ^ a;
            a = gf_double(a);
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic void build_sub_lut();
        logic [7:0] inv;
        logic [7:0] b;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++)
                inv = gf_mul(inv, x[7:0]);
            if (x == 0)
                inv = 8'h00;
            b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_lut[x] = b;
        end
    endfunction

    function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] plain);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] rk [16];
        logic [7:0] g [4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, sum;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            st[i] = plain[127 - 8 * i -: 8];
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = st[i] ^ rk[i];
        end
        for (int r = 1; r <= ROUNDS; r++)
        begin
            g[0] = sub_lut[rk[13]] ^ rc;
            g[1] = sub_lut[rk[14]];
            g[2] = sub_lut[rk[15]];
            g[3] = sub_lut[rk[12]];
            rc = gf_double(rc);
            for (int i = 0; i < 4; i++)
                rk[i] = rk[i] ^ g[i];
            for (int i = 4; i < 16; i++)
                rk[i] = rk[i] ^ rk[i - 4];
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[w + 4 * c] = sub_lut[st[w + 4 * ((c + w) % 4)]];
            if (r < ROUNDS)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tmp[4 * c];
                    a1 = tmp[4 * c + 1];
                    a2 = tmp[4 * c + 2];
                    a3 = tmp[4 * c + 3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    tmp[4 * c]     = a0 ^ sum ^ gf_double(a0 ^ a1);
                    tmp[4 * c + 1] = a1 ^ sum ^ gf_double(a1 ^ a2);
                    tmp[4 * c + 2] = a2 ^ sum ^ gf_double(a2 ^ a3);
                    tmp[4 * c + 3] = a3 ^ sum ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = tmp[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    task automatic write_reg(logic idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drain the pipeline, then load a new key
    task automatic load_key(logic [127:0] key);
        in_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (ROUNDS + 3) @(posedge clk);
        write_reg(CFG_KEY_HIGH, key[127:64]);
        write_reg(CFG_KEY_LOW, key[63:0]);
        cur_key = key;
    endtask

    task automatic send_item(logic [127:0] plain, bit typed, logic [127:0] cipher);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= plain;
        do
            @(posedge clk);
        while (!in_ready);
        cipher_q.insert(cipher_q.size(),
                        aes_out_t'(typed ? cipher : encrypt_block(cur_key, plain)));
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        aes_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_q.size() == 0)
            begin
                $display("%0t: expected no item actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = cipher_q.pop_front();
                if (out_data.cipher_high !== want.cipher_high)
                begin
                    $display("%0t: cipher_high expected %h actual %h", $time,
                             want.cipher_high, out_data.cipher_high);
                    errors++;
                end
                if (out_data.cipher_low !== want.cipher_low)
                begin
                    $display("%0t: cipher_low expected %h actual %h", $time,
                             want.cipher_low, out_data.cipher_low);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        vector_t vecs [$];
        logic [127:0] k;
        logic [127:0] p;
        int r;
        errors = 0;
        cycles = 0;
        send_idle = 10;
        recv_idle = 72;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY_HIGH;
        cfg_data = '0;
        cur_key = '0;
        build_sub_lut();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key after reset is zero
        vecs.insert(vecs.size(), vector_t'{128'h0, 128'h0,
                    128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1});
        vecs.insert(vecs.size(), vector_t'{128'h0, '1, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{128'h000102030405060708090a0b0c0d0e0f,
                    128'h00112233445566778899aabbccddeeff,
                    128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1});
        vecs.insert(vecs.size(), vector_t'{128'h000102030405060708090a0b0c0d0e0f,
                    128'h0, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{128'h000102030405060708090a0b0c0d0e0f,
                    '1, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{'1, 128'h0, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{'1, '1, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{'1, {64'h0, {64{1'b1}}}, 128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{{{64{1'b1}}, 64'h0}, {{64{1'b1}}, 64'h0},
                    128'h0, 1'b0});
        vecs.insert(vecs.size(), vector_t'{{64'h0, {64{1'b1}}},
                    128'h80000000000000000000000000000001, 128'h0, 1'b0});

        foreach (vecs[i])
        begin
            if (vecs[i].key !== cur_key || i == 0)
                load_key(vecs[i].key);
            send_item(vecs[i].plain, vecs[i].typed, vecs[i].cipher);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 3)
                0: begin send_idle = 10; recv_idle = 72; end
                1: begin send_idle = 72; recv_idle = 10; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            k = {$urandom, $urandom, $urandom, $urandom};
            if (ph == 1)
                k = '1;
            if (ph == 3)
                k = '0;
            in_valid <= 1'b0;
            load_key(k);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p = {$urandom, $urandom, $urandom, $urandom};
                r = $urandom_range(19);
                if (r == 0)
                    p = '0;
                else if (r == 1)
                    p = '1;
                send_item(p, 1'b0, 128'h0);
            end
        end
        in_valid <= 1'b0;

        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (ROUNDS + 5) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ aes128_block_encrypt_unit.f @@
rtl/aes_pkg.sv
rtl/aes_round_cell.sv
rtl/aes128_block_encrypt_unit.sv
rtl/aes_checker.sv
bench/tb_top.sv
